@@ sv/cfl_pkg.sv @@
`timescale 1ns / 1ps
package cfl_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DW = 32;

  typedef enum logic [1:0] {
    OP_VEL_X = 2'd0,
    OP_VEL_Y = 2'd1,
    OP_SND   = 2'd2,
    OP_DT    = 2'd3
  } div_op_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;      // capture input item
    logic    div_start; // start divider with op
    div_op_t op;
    logic    sqrt_start;
    logic    accum;     // fold speed into running max
    logic    skip;      // density nonpositive
    logic    finish;    // build result, clear sweep state
  } cfl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic rho_bad;
    logic pres_neg;
    logic last;
  } cfl_sts_t;
endpackage

@@ sv/cfl_ctrl.sv @@
`timescale 1ns / 1ps
module cfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  cfl_pkg::cfl_sts_t sts,
  output cfl_pkg::cfl_cmd_t cmd
);
  import cfl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DX, S_WX, S_DY, S_WY, S_DS, S_WS, S_SQ, S_WQ,
    S_ACC, S_DT, S_WT, S_FIN
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.op = OP_VEL_X;
    unique case (state)
      S_IDLE:  cmd.load = in_valid;
      S_DX:    begin cmd.div_start = 1'b1; cmd.op = OP_VEL_X; end
      S_DY:    begin cmd.div_start = 1'b1; cmd.op = OP_VEL_Y; end
      S_DS:    begin cmd.div_start = 1'b1; cmd.op = OP_SND; end
      S_SQ:    cmd.sqrt_start = 1'b1;
      S_ACC:   cmd.accum = 1'b1;
      S_CHECK: cmd.skip = sts.rho_bad;
      S_DT:    begin cmd.div_start = 1'b1; cmd.op = OP_DT; end
      S_FIN:   cmd.finish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_CHECK;
        S_CHECK: state <= sts.rho_bad ? (sts.last ? S_DT : S_IDLE) : S_DX;
        S_DX:    state <= S_WX;
        S_WX:    if (sts.div_done) state <= S_DY;
        S_DY:    state <= S_WY;
        S_WY:    if (sts.div_done) state <= sts.pres_neg ? S_ACC : S_DS;
        S_DS:    state <= S_WS;
        S_WS:    if (sts.div_done) state <= S_SQ;
        S_SQ:    state <= S_WQ;
        S_WQ:    if (sts.sqrt_done) state <= S_ACC;
        S_ACC:   state <= sts.last ? S_DT : S_IDLE;
        S_DT:    state <= S_WT;
        S_WT:    if (sts.div_done) state <= S_FIN;
        S_FIN:   if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/cfl_div.sv @@
`timescale 1ns / 1ps
// 64 / 64 restoring divider, one quotient bit per cycle
module cfl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] rem;
  logic [64:0] trial;
  logic [63:0] dreg;

  assign trial = {rem[63:0], quo[63]} - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        quo  <= num;
        dreg <= den;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[63:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ sv/cfl_sqrt.sv @@
`timescale 1ns / 1ps
// Floor square root of a 64-bit value, one result bit per cycle
module cfl_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);
  logic [5:0]  cnt;
  logic        busy;
  logic [63:0] x;
  logic [33:0] rem;
  logic [33:0] trial;

  assign trial = {rem[31:0], x[63:62]} - {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        x    <= rad;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x <= {x[61:0], 2'b00};
        if (!trial[33]) begin
          rem  <= trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= {rem[31:0], x[63:62]};
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ sv/cfl_dp.sv @@
`timescale 1ns / 1ps
module cfl_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [128:0]      in_item,
  input  logic [31:0]       cfl_number,
  input  logic [31:0]       spacing_x,
  input  logic [31:0]       spacing_y,
  input  logic [31:0]       spacing_z,
  input  cfl_pkg::cfl_cmd_t cmd,
  output cfl_pkg::cfl_sts_t sts,
  output logic              out_valid,
  input  logic              out_take,
  output logic [34:0]       out_item
);
  import cfl_pkg::*;

  localparam logic [63:0] C2_LIM = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;

  logic signed [31:0] rho, mx, my, pres;
  logic               last;
  logic [31:0] ux, vmax, maxs, hmin;
  logic [1:0]  flags;
  logic [63:0] num, den, quo;
  logic        div_done, sqrt_done;
  logic [31:0] root;
  logic [32:0] speed;
  logic [31:0] vx_mag, vy_mag;
  logic [63:0] c2;
  logic [31:0] vq;

  assign vx_mag = mx[31] ? 32'(-mx) : mx;
  assign vy_mag = my[31] ? 32'(-my) : my;
  assign vq = (quo[63:32] != '0) ? '1 : quo[31:0];
  assign c2 = (quo > C2_LIM) ? C2_LIM : quo;

  always_comb begin
    hmin = spacing_x;
    if (spacing_y < hmin) hmin = spacing_y;
    if (spacing_z < hmin) hmin = spacing_z;
  end

  always_comb begin
    unique case (cmd.op)
      OP_VEL_X: begin num = {vx_mag, 32'd0} >> (32 - FRAC_BITS); den = {32'd0, rho}; end
      OP_VEL_Y: begin num = {vy_mag, 32'd0} >> (32 - FRAC_BITS); den = {32'd0, rho}; end
      OP_SND:   begin
        num = ({32'd0, pres} * 64'd7) << FRAC_BITS;
        den = {32'd0, rho} * 64'd5;
      end
      // numerator formed in the start cycle so the divider captures it
      OP_DT:    begin num = 64'(cfl_number) * 64'(hmin); den = {32'd0, maxs}; end
      default:  begin num = '0; den = '1; end
    endcase
  end

  cfl_div u_div (.clk, .rst, .start(cmd.div_start), .num, .den, .done(div_done), .quo);
  cfl_sqrt u_sqrt (.clk, .rst, .start(cmd.sqrt_start), .rad(c2 << FRAC_BITS),
    .done(sqrt_done), .root);

  assign speed = {1'b0, vmax} + {1'b0, (pres[31] ? 32'd0 : root)};

  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.rho_bad   = rho[31] || (rho == '0);
  assign sts.pres_neg  = pres[31];
  assign sts.last      = last;

  logic ux_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      maxs      <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
      ux_phase  <= 1'b0;
    end else begin
      out_valid <= cmd.finish || (out_valid && !out_take);
      if (cmd.load) begin
        {last, pres, my, mx, rho} <= in_item;
        ux_phase <= 1'b0;
      end
      if (cmd.skip) flags[0] <= 1'b1;
      if (div_done && !ux_phase && !cmd.finish) begin
        ux <= vq;
        ux_phase <= 1'b1;
      end else if (div_done && ux_phase) begin
        vmax <= (ux > vq) ? ux : vq;
        ux_phase <= 1'b0;
        if (pres[31]) flags[1] <= 1'b1;
      end
      if (cmd.accum && !speed[32] && speed[31:0] > maxs) maxs <= speed[31:0];
      else if (cmd.accum && speed[32]) maxs <= '1;
      if (cmd.finish) begin
        out_item  <= (maxs == '0) ? {1'b1, flags, 32'hFFFF_FFFF}
                                  : {1'b0, flags, vq};
        maxs  <= '0;
        flags <= '0;
      end
    end
  end
endmodule

@@ sv/cfl_timestep_reduction_top.sv @@
`timescale 1ns / 1ps
// Each divide runs on a 64-step serial divider and the root on a 32-step serial root.
// One cell in flight: a new cell is taken only once the previous one is done; a last
//   cell also runs the time-step divide before its result is offered, and skipped cells
//   and cells with negative pressure bypass the serial units they do not need.
// Reset: synchronous, active high; registers return to cfl 0.5, spacing 1.0,
//   running max and flags cleared, output empty.
module cfl_timestep_reduction_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // density, momentum_x, momentum_y, pressure
  input  logic         s_tlast,   // last_cell
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // time_step, status, zero pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import cfl_pkg::*;

  localparam logic [1:0] R_CFL = 2'd0;
  localparam logic [1:0] R_SX  = 2'd1;
  localparam logic [1:0] R_SY  = 2'd2;
  localparam logic [1:0] R_SZ  = 2'd3;

  logic [31:0] cfl_number, spacing_x, spacing_y, spacing_z;
  cfl_cmd_t    cmd;
  cfl_sts_t    sts;
  logic [34:0] out_item;
  logic        out_free;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfl_number <= 32'(1) << (FRAC_BITS - 1);
      spacing_x  <= 32'(1) << FRAC_BITS;
      spacing_y  <= 32'(1) << FRAC_BITS;
      spacing_z  <= 32'(1) << FRAC_BITS;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        R_CFL: cfl_number <= pwdata;
        R_SX:  spacing_x  <= pwdata;
        R_SY:  spacing_y  <= pwdata;
        R_SZ:  spacing_z  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      R_CFL:   prdata = cfl_number;
      R_SX:    prdata = spacing_x;
      R_SY:    prdata = spacing_y;
      R_SZ:    prdata = spacing_z;
      default: prdata = '0;
    endcase
  end

  // result slot frees when empty or being taken
  assign out_free = !m_tvalid || m_tready;

  cfl_ctrl u_ctrl (.clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .out_free, .sts, .cmd);

  cfl_dp u_dp (.clk, .rst, .in_item({s_tlast, s_tdata}), .cfl_number, .spacing_x,
    .spacing_y, .spacing_z, .cmd, .sts, .out_valid(m_tvalid),
    .out_take(m_tready), .out_item);

  assign m_tdata = {5'd0, out_item};
endmodule

@@ dv/cfl_timestep_reduction_top_test.sv @@
`timescale 1ns / 1ps
module cfl_timestep_reduction_top_test;
  import cfl_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // cycles with no item moving on either side
  localparam int LONG_HOLD  = 3000;   // receiver back-pressure stretch
  localparam int DRAIN_WAIT = 400;    // a bit over one last-cell latency

  // register indexes, byte address is 4*index
  localparam int REG_CFL = 0;
  localparam int REG_SX  = 1;
  localparam int REG_SY  = 2;
  localparam int REG_SZ  = 3;

  typedef struct {
    logic signed [31:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] pressure;
    logic               last_cell;
  } cell_t;

  typedef struct {
    logic [31:0] time_step;
    logic [2:0]  status;
  } step_t;

  // Tracks the sweep the way the block should, queues expected time steps.
  class cfl_scoreboard;
    longint unsigned cfl, sx, sy, sz;
    longint unsigned max_speed;
    logic [1:0]      flags;
    step_t           steps_due[$];
    int              errors;
    int              n_cells;

    function new();
      cfl = 64'd1 << (FRAC_BITS - 1);
      sx = 64'd1 << FRAC_BITS;
      sy = sx;
      sz = sx;
      max_speed = 0;
      flags = 0;
      errors = 0;
      n_cells = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
      case (idx)
        REG_CFL: cfl = v;
        REG_SX:  sx = v;
        REG_SY:  sy = v;
        REG_SZ:  sz = v;
        default: ;
      endcase
    endfunction

    function longint unsigned sat32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function longint unsigned mag(logic signed [31:0] v);
      longint signed s;
      s = v;
      return (s < 0) ? -s : s;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void note_cell(cell_t c);
      longint signed   rho, pres;
      longint unsigned r, ux, uy, vmax, snd, c2, lim, spd, h, dt;
      step_t           e;
      n_cells++;
      rho = c.density;
      pres = c.pressure;
      if (rho <= 0) begin
        flags[0] = 1'b1;   // cell skipped
      end else begin
        r = rho;
        ux = sat32((mag(c.momentum_x) << FRAC_BITS) / r);
        uy = sat32((mag(c.momentum_y) << FRAC_BITS) / r);
        vmax = (ux > uy) ? ux : uy;
        snd = 0;
        if (pres < 0) begin
          flags[1] = 1'b1;
        end else begin
          c2 = ((64'd7 * longint'(pres)) << FRAC_BITS) / (64'd5 * r);
          lim = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;
          if (c2 > lim) c2 = lim;
          snd = floor_sqrt(c2 << FRAC_BITS);
        end
        spd = sat32(vmax + snd);
        if (spd > max_speed) max_speed = spd;
      end
      if (c.last_cell) begin
        h = sx;
        if (sy < h) h = sy;
        if (sz < h) h = sz;
        e.status = {1'b0, flags};
        if (max_speed == 0) begin
          dt = 64'hFFFF_FFFF;
          e.status[2] = 1'b1;
        end else begin
          dt = sat32((cfl * h) / max_speed);
        end
        e.time_step = dt[31:0];
        steps_due.push_back(e);
        max_speed = 0;
        flags = 0;
      end
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_step(logic [31:0] ts, logic [2:0] st);
      step_t e;
      if (steps_due.size() == 0) begin
        report($sformatf("unexpected item ts=%h st=%b", ts, st));
      end else begin
        e = steps_due.pop_front();
        if (ts !== e.time_step)
          report($sformatf("time_step %h, want %h", ts, e.time_step));
        if (st !== e.status)
          report($sformatf("status %b, want %b", st, e.status));
      end
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // density, momentum_x, momentum_y, pressure
  logic         s_tlast;   // last_cell
  logic         m_tvalid;
  logic         m_tready;
  logic [39:0]  m_tdata;   // time_step, status, zero pad
  logic         psel, penable, pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  cfl_scoreboard sb = new();

  cfl_timestep_reduction_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Receiver: stretches of full speed, stretches on a random stall pattern,
  // and one long hold-off once a few hundred cells are in, so the single
  // in-flight slot fills and s_tready drops while cells keep coming.
  int          rx_cyc = 0;
  logic [15:0] rx_pat = 16'hFFFF;
  int          hold_left = 0;
  bit          hold_done = 0;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_step(m_tdata[31:0], m_tdata[34:32]);
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc[7:0] == 0) rx_pat <= $urandom;
    if (!hold_done && sb.n_cells >= 200) begin
      hold_done <= 1;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (rx_cyc[9:8] == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= rx_pat[rx_cyc[3:0]];
    end
  end

  // Watchdog on cycles where nothing moves.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task apb_write(int idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx * 4);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);   // register takes the value here
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task write_regs(logic [31:0] c, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    apb_write(REG_CFL, c);
    apb_write(REG_SX, x);
    apb_write(REG_SY, y);
    apb_write(REG_SZ, z);
  endtask

  // Present one cell, hold it until taken, then optionally go quiet.
  // With gap 0 the next call keeps s_tvalid high without a low pulse.
  task send_cell(cell_t c, int gap);
    s_tvalid <= 1'b1;
    s_tdata <= {c.pressure, c.momentum_y, c.momentum_x, c.density};
    s_tlast <= c.last_cell;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_cell(c);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function cell_t mk(int d, int mx, int my, int p, bit l);
    cell_t c;
    c.density = d;
    c.momentum_x = mx;
    c.momentum_y = my;
    c.pressure = p;
    c.last_cell = l;
    return c;
  endfunction

  function logic [31:0] rand_field();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0010_0000);
      2: return -$urandom_range(0, 32'h0010_0000);
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  // Mostly physical cells with random content, some noise in sign and size.
  function cell_t rand_cell();
    cell_t c;
    if ($urandom_range(0, 9) < 8) begin
      c.density = $urandom_range(1, ($urandom_range(0, 1)) ? 32'h0004_0000 : 32'h7FFF_FFFF);
      c.pressure = $urandom_range(0, ($urandom_range(0, 1)) ? 32'h0010_0000 : 32'h7FFF_FFFF);
    end else begin
      c.density = rand_field();
      c.pressure = rand_field();
    end
    c.momentum_x = rand_field();
    c.momentum_y = rand_field();
    c.last_cell = ($urandom_range(0, 7) == 0);
    return c;
  endfunction

  task drain();
    while (sb.steps_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // sender bursts: run of back-to-back cells, then a random gap
  int burst_left = 0;
  function int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
  endfunction

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, default registers
    send_cell(mk(0, 0, 0, 0, 1), 0);                         // empty sweep: zero max speed
    send_cell(mk(32'h0001_0000, 32'h0002_0000, 0, 32'h0001_0000, 1), 2);
    send_cell(mk(0, 5, 5, 5, 0), 0);                         // zero density, skipped
    send_cell(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0), 0); // most negative density
    send_cell(mk(32'h0001_0000, 0, 0, 32'h8000_0000, 1), 3); // negative pressure
    send_cell(mk(1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1), 0); // quotient overflow
    send_cell(mk(1, 0, 0, 32'h7FFF_FFFF, 1), 0);             // huge sound speed
    send_cell(mk(32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1), 1);
    send_cell(mk(32'h7FFF_FFFF, 0, 0, 0, 1), 0);             // zero speed, dt all ones
    send_cell(mk(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0), 0);
    send_cell(mk(32'h0000_8000, 32'h8000_0000, 32'h8000_0000, 32'h0003_0000, 1), 0);
    s_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: write_regs(0, 1, 1, 1);
        2: write_regs(32'h0000_8000, 1, 32'hFFFF_FFFF, 32'h0001_0000);
        3: write_regs($urandom, $urandom_range(1, 32'hFFFF_FFFF),
                      $urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 32'hFFFF_FFFF));
        4: write_regs($urandom_range(0, 32'h0002_0000), $urandom_range(1, 32'h0004_0000),
                      $urandom_range(1, 32'h0004_0000), 1);
        default: write_regs(32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      endcase
      if (ph == 1) begin
        send_cell(mk(0, 0, 0, 0, 1), 0);   // zero max speed with cfl zero
        send_cell(mk(32'h0001_0000, 32'h0001_0000, 0, 0, 1), 0);
      end
      for (int i = 0; i < 232; i++) send_cell(rand_cell(), next_gap());
      send_cell(mk(32'h0001_0000, 0, 0, 32'h0001_0000, 1), 0);  // close the sweep
      s_tvalid <= 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.steps_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
